// ===== src/i2cbb_pkg.sv =====
// package for the bit-banged i2c master: payload structs, command codes,
// pin-operation encoding and the per-command sequence tables
// no dependencies
`default_nettype none

package i2cbb_pkg;

   localparam int unsigned HALF_PERIOD_W = 8;
   localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 8'h10;

   typedef enum logic [2:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_ACK   = 3'd4,
      CMD_NACK  = 3'd5
   } cmd_type;

   // pin operation bits
   localparam int unsigned OP_LVL_BIT = 0;
   localparam int unsigned OP_SDA_BIT = 1;
   localparam int unsigned OP_SMP_BIT = 2;
   localparam int unsigned OP_DAT_BIT = 3;

   localparam logic [3:0] OP_NONE = 4'b0000;
   localparam logic [3:0] OP_LVL  = 4'b0001;
   localparam logic [3:0] OP_SDA  = 4'b0010;
   localparam logic [3:0] OP_SMP  = 4'b0100;
   localparam logic [3:0] OP_DAT  = 4'b1000;

   localparam logic [3:0] LOOP_PHASE = 4'd2;
   localparam logic [3:0] LAST_BIT   = 4'd7;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] req_type;
      logic [7:0] write_byte;
      logic       scl_in;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_bit;
   } rsp_item_type;

   function automatic logic [3:0] seq_len(input logic [2:0] cmd);
      logic [3:0] len;
      case (cmd)
         CMD_START: len = 4'd4;
         CMD_STOP:  len = 4'd3;
         CMD_WRITE: len = 4'd6;
         CMD_READ:  len = 4'd3;
         CMD_ACK:   len = 4'd4;
         CMD_NACK:  len = 4'd4;
         default:   len = 4'd4;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] seq_op(input logic [2:0] cmd, input logic [3:0] phase);
      logic [2:0] p;
      logic [3:0] op;
      p  = (phase > 4'd5) ? 3'd0 : phase[2:0];
      op = OP_NONE;
      case (cmd)
         CMD_STOP: begin
            case (p)
               3'd0:    op = OP_SDA;
               3'd1:    op = OP_LVL;
               3'd2:    op = OP_SDA | OP_LVL;
               default: op = OP_NONE;
            endcase
         end
         CMD_WRITE: begin
            case (p)
               3'd0:    op = OP_DAT | OP_SDA;
               3'd1:    op = OP_LVL;
               3'd3:    op = OP_SDA | OP_LVL;
               3'd4:    op = OP_LVL | OP_SMP;
               default: op = OP_NONE;
            endcase
         end
         CMD_READ: begin
            case (p)
               3'd0:    op = OP_SDA | OP_LVL;
               3'd1:    op = OP_LVL | OP_SMP;
               default: op = OP_NONE;
            endcase
         end
         CMD_ACK: begin
            case (p)
               3'd0:    op = OP_SDA;
               3'd1:    op = OP_LVL;
               3'd3:    op = OP_SDA | OP_LVL;
               default: op = OP_NONE;
            endcase
         end
         CMD_NACK: begin
            case (p)
               3'd0:    op = OP_SDA | OP_LVL;
               3'd1:    op = OP_LVL;
               3'd3:    op = OP_SDA | OP_LVL;
               default: op = OP_NONE;
            endcase
         end
         default: begin
            case (p)
               3'd0:    op = OP_LVL;
               3'd1:    op = OP_SDA | OP_LVL;
               3'd2:    op = OP_SDA;
               default: op = OP_NONE;
            endcase
         end
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== src/i2cbb_in_reg.sv =====
// input register stage: holds one tick transaction until the engine takes it
// depends on i2cbb_pkg
`default_nettype none

module i2cbb_in_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire i2cbb_pkg::req_item_type req_item,
   input  wire logic                   down_ready,
   output logic                        item_valid,
   output i2cbb_pkg::req_item_type     item
);
   import i2cbb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_stall  = valid_ff & ~down_ready;
   assign accept     = req_valid & ~req_stall;
   assign valid_in   = accept | (valid_ff & ~down_ready);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2cbb_engine.sv =====
// bus engine: command state, half-period register and the per-tick update
// depends on i2cbb_pkg
`default_nettype none

module i2cbb_engine (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [7:0]              csr_data,
   input  wire logic                    step,
   input  wire i2cbb_pkg::req_item_type item,
   output i2cbb_pkg::rsp_item_type      result
);
   import i2cbb_pkg::*;

   logic [7:0] half_period_ff;
   logic [2:0] cmd_ff, cmd_in;
   logic       busy_ff, busy_in;
   logic [3:0] phase_ff, phase_in;
   logic [3:0] bits_ff, bits_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] delay_ff, delay_in;
   logic       scl_ff, scl_in_nx;
   logic       sda_ff, sda_in_nx;
   logic       ack_ff, ack_in;
   logic [7:0] rd_ff, rd_in;
   logic       done;
   logic       apply;
   logic       fin;
   logic [7:0] hp_eff;
   logic [7:0] dec;
   logic [3:0] op;
   logic [3:0] op2;
   logic       lvl;

   assign hp_eff = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;

   always_comb begin
      cmd_in    = cmd_ff;
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      delay_in  = delay_ff;
      scl_in_nx = scl_ff;
      sda_in_nx = sda_ff;
      ack_in    = ack_ff;
      rd_in     = rd_ff;
      done      = 1'b0;
      apply     = 1'b0;
      fin       = 1'b0;
      dec       = delay_ff - 8'd1;
      op        = seq_op(cmd_ff, phase_ff);
      op2       = OP_NONE;
      lvl       = 1'b0;
      if (busy_ff) begin
         if (delay_ff == 8'd0) begin
            if (item.scl_in) begin
               delay_in = hp_eff;
            end
         end else begin
            delay_in = dec;
            if (dec == 8'd0) begin
               if (op[OP_SMP_BIT]) begin
                  if (cmd_ff == CMD_WRITE) begin
                     ack_in = item.sda_in;
                  end else begin
                     shift_in = {shift_ff[6:0], item.sda_in};
                  end
               end
               if (phase_ff == LOOP_PHASE && bits_ff < LAST_BIT &&
                   (cmd_ff == CMD_WRITE || cmd_ff == CMD_READ)) begin
                  bits_in = bits_ff + 4'd1;
                  if (cmd_ff == CMD_WRITE) begin
                     shift_in = {shift_in[6:0], 1'b0};
                     phase_in = 4'd0;
                  end else begin
                     phase_in = 4'd1;
                  end
               end else begin
                  phase_in = phase_ff + 4'd1;
                  if (phase_in >= seq_len(cmd_ff)) begin
                     fin = 1'b1;
                     if (cmd_ff == CMD_READ) begin
                        rd_in = shift_in;
                     end
                  end
               end
               if (fin) begin
                  busy_in  = 1'b0;
                  phase_in = 4'd0;
                  done     = 1'b1;
               end else begin
                  apply = 1'b1;
               end
            end
         end
      end else if (item.cmd_valid && item.req_type <= CMD_NACK) begin
         cmd_in   = item.req_type;
         busy_in  = 1'b1;
         phase_in = 4'd0;
         bits_in  = 4'd0;
         shift_in = (item.req_type == CMD_WRITE) ? item.write_byte : 8'd0;
         apply    = 1'b1;
      end
      if (apply) begin
         op2 = seq_op(cmd_in, phase_in);
         lvl = op2[OP_DAT_BIT] ? shift_in[7] : op2[OP_LVL_BIT];
         if (op2[OP_SDA_BIT]) begin
            sda_in_nx = lvl;
            delay_in  = hp_eff;
         end else begin
            scl_in_nx = lvl;
            delay_in  = lvl ? 8'd0 : hp_eff;
         end
      end
   end

   always_comb begin
      result.scl_release = scl_in_nx;
      result.sda_release = sda_in_nx;
      result.busy_res    = busy_in;
      result.done_res    = done;
      result.read_byte   = rd_in;
      result.ack_bit     = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_write) begin
         half_period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= CMD_START;
         busy_ff  <= 1'b0;
         phase_ff <= 4'd0;
         bits_ff  <= 4'd0;
         shift_ff <= 8'd0;
         delay_ff <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b1;
         rd_ff    <= 8'd0;
      end else if (step) begin
         cmd_ff   <= cmd_in;
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
         delay_ff <= delay_in;
         scl_ff   <= scl_in_nx;
         sda_ff   <= sda_in_nx;
         ack_ff   <= ack_in;
         rd_ff    <= rd_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2cbb_out_reg.sv =====
// result register: holds one result transaction while the consumer stalls
// depends on i2cbb_pkg
`default_nettype none

module i2cbb_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire i2cbb_pkg::rsp_item_type result,
   output logic                         up_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output i2cbb_pkg::rsp_item_type      rsp_item
);
   import i2cbb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign up_ready  = ~valid_ff | ~rsp_stall;
   assign valid_in  = load | (valid_ff & rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2c_bitbang_master_core.sv =====
// top level of the bit-banged i2c master: input register, bus engine, result register
// depends on i2cbb_pkg, i2cbb_in_reg, i2cbb_engine, i2cbb_out_reg
//
// channel   handshake          payload
// req       req_valid/stall    req_item  (one bus tick: command offer and line samples)
// rsp       rsp_valid/stall    rsp_item  (pin levels and status after that tick)
// csr       csr_valid/ready    csr_data  (half_period)
//
// one transaction per cycle while rsp is not stalled; each passes from req to rsp through
// the input register, then the engine update into the result register
// reset is synchronous; half_period resets to 16, both lines released
// a stall on rsp holds the engine and, once the input register is full, raises req_stall
// csr_ready is always high; write half_period only while the bus is idle
`default_nettype none

module i2c_bitbang_master_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire i2cbb_pkg::req_item_type req_item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output i2cbb_pkg::rsp_item_type      rsp_item,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [7:0]              csr_data
);
   import i2cbb_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         out_ready;
   logic         step;
   rsp_item_type result;

   assign csr_ready = 1'b1;
   assign step      = item_valid & out_ready;

   i2cbb_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .down_ready (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cbb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .step      (step),
      .item      (item),
      .result    (result)
   );

   i2cbb_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (result),
      .up_ready  (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_i2c_bitbang_master_core.sv =====
// self-checking testbench for i2c_bitbang_master_core: drives bus ticks with pin samples,
// predicts pin levels and status per tick and compares every rsp transaction
// depends on i2cbb_pkg and the i2c_bitbang_master_core rtl
module tb_i2c_bitbang_master_core;
   import i2cbb_pkg::*;

   localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;

   i2c_bitbang_master_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // stimulus knobs, percentages
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned scl_low_pct = 0;
   int unsigned sda_one_pct = 50;
   int unsigned noise_pct = 0;

   int unsigned  ticks_sent = 0;
   int unsigned  mismatch_count = 0;
   rsp_item_type bus_levels_q[$];
   rsp_item_type want_levels;

   // bus engine prediction
   logic [7:0] half_period = HALF_PERIOD_RESET;
   cmd_type    eng_cmd = CMD_START;
   logic       eng_busy = 1'b0;
   logic [3:0] eng_step = '0;
   logic [3:0] eng_bits = '0;
   logic [7:0] eng_shift = '0;
   logic [7:0] eng_wait = '0;
   logic       eng_scl = 1'b1;
   logic       eng_sda = 1'b1;
   logic       eng_ack = 1'b1;
   logic [7:0] eng_rx = '0;

   function automatic logic [3:0] cmd_steps(input cmd_type c);
      case (c)
         CMD_STOP:  return 4'd3;
         CMD_WRITE: return 4'd6;
         CMD_READ:  return 4'd3;
         default:   return 4'd4;
      endcase
   endfunction

   // pin operation per phase, listed from phase 5 down to phase 0
   function automatic logic [3:0] pin_op(input cmd_type c, input logic [3:0] s);
      logic [5:0][3:0] ops;
      case (c)
         CMD_STOP:
            ops = {OP_NONE, OP_NONE, OP_NONE, OP_SDA | OP_LVL, OP_LVL, OP_SDA};
         CMD_WRITE:
            ops = {OP_NONE, OP_LVL | OP_SMP, OP_SDA | OP_LVL, OP_NONE, OP_LVL, OP_DAT | OP_SDA};
         CMD_READ:
            ops = {OP_NONE, OP_NONE, OP_NONE, OP_NONE, OP_LVL | OP_SMP, OP_SDA | OP_LVL};
         CMD_ACK:
            ops = {OP_NONE, OP_NONE, OP_SDA | OP_LVL, OP_NONE, OP_LVL, OP_SDA};
         CMD_NACK:
            ops = {OP_NONE, OP_NONE, OP_SDA | OP_LVL, OP_NONE, OP_LVL, OP_SDA | OP_LVL};
         default:
            ops = {OP_NONE, OP_NONE, OP_NONE, OP_SDA, OP_SDA | OP_LVL, OP_LVL};
      endcase
      return (s > 4'd5) ? ops[0] : ops[s];
   endfunction

   function automatic logic [7:0] wait_ticks();
      return (half_period == 8'd0) ? 8'd1 : half_period;
   endfunction

   function automatic void drive_pin();
      logic [3:0] op;
      logic       lvl;
      op  = pin_op(eng_cmd, eng_step);
      lvl = op[OP_LVL_BIT];
      if (op[OP_DAT_BIT]) lvl = eng_shift[7];
      if (op[OP_SDA_BIT]) begin
         eng_sda  = lvl;
         eng_wait = wait_ticks();
      end else begin
         eng_scl  = lvl;
         eng_wait = lvl ? 8'd0 : wait_ticks();
      end
   endfunction

   // closes the current pin operation, returns 1 when the command is complete
   function automatic logic close_pin(input logic sda);
      logic [3:0] op;
      op = pin_op(eng_cmd, eng_step);
      if (op[OP_SMP_BIT]) begin
         if (eng_cmd == CMD_WRITE) eng_ack = sda;
         else eng_shift = {eng_shift[6:0], sda};
      end
      if (eng_step == LOOP_PHASE && eng_bits < LAST_BIT &&
          (eng_cmd == CMD_WRITE || eng_cmd == CMD_READ)) begin
         eng_bits = eng_bits + 4'd1;
         if (eng_cmd == CMD_WRITE) begin
            eng_shift = eng_shift << 1;
            eng_step  = 4'd0;
         end else begin
            eng_step = 4'd1;
         end
         return 1'b0;
      end
      eng_step = eng_step + 4'd1;
      if (eng_step >= cmd_steps(eng_cmd)) begin
         if (eng_cmd == CMD_READ) eng_rx = eng_shift;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void predict_tick(input req_item_type it);
      rsp_item_type r;
      logic         done;
      done = 1'b0;
      if (eng_busy) begin
         if (eng_wait == 8'd0) begin
            if (it.scl_in) eng_wait = wait_ticks();
         end else begin
            eng_wait = eng_wait - 8'd1;
            if (eng_wait == 8'd0) begin
               if (close_pin(it.sda_in)) begin
                  eng_busy = 1'b0;
                  eng_step = 4'd0;
                  done     = 1'b1;
               end else begin
                  drive_pin();
               end
            end
         end
      end else if (it.cmd_valid && it.req_type <= CMD_NACK) begin
         eng_cmd   = cmd_type'(it.req_type);
         eng_busy  = 1'b1;
         eng_step  = 4'd0;
         eng_bits  = 4'd0;
         eng_shift = (eng_cmd == CMD_WRITE) ? it.write_byte : 8'd0;
         drive_pin();
      end
      r.scl_release = eng_scl;
      r.sda_release = eng_sda;
      r.busy_res    = eng_busy;
      r.done_res    = done;
      r.read_byte   = eng_rx;
      r.ack_bit     = eng_ack;
      bus_levels_q.push_back(r);
   endfunction

   // result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_levels_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %h", $time, rsp_item);
            mismatch_count++;
         end else begin
            want_levels = bus_levels_q.pop_front();
            check_field("scl_release", want_levels.scl_release, rsp_item.scl_release);
            check_field("sda_release", want_levels.sda_release, rsp_item.sda_release);
            check_field("busy_res", want_levels.busy_res, rsp_item.busy_res);
            check_field("done_res", want_levels.done_res, rsp_item.done_res);
            check_field("read_byte", want_levels.read_byte, rsp_item.read_byte);
            check_field("ack_bit", want_levels.ack_bit, rsp_item.ack_bit);
         end
      end
   end

   // request side
   task automatic send_tick(input req_item_type it);
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_tick(it);
      ticks_sent++;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
   endtask

   task automatic bus_tick(input logic cmd_valid, input logic [2:0] code, input logic [7:0] data);
      req_item_type it;
      it.cmd_valid  = cmd_valid;
      it.req_type   = code;
      it.write_byte = data;
      it.scl_in     = ($urandom_range(99) >= scl_low_pct);
      it.sda_in     = ($urandom_range(99) < sda_one_pct);
      send_tick(it);
   endtask

   task automatic run_command(input logic [2:0] code, input logic [7:0] data);
      bus_tick(1'b1, code, data);
      while (eng_busy) begin
         bus_tick($urandom_range(99) < noise_pct, $urandom_range(7), $urandom);
      end
   endtask

   task automatic write_half_period(input logic [7:0] value);
      scl_low_pct = 0;
      while (eng_busy) bus_tick(1'b0, CMD_START, 8'h00);
      req_valid <= 1'b0;
      while (bus_levels_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      half_period = value;
   endtask

   task automatic test_reset_period();
      run_command(CMD_START, 8'h00);
      run_command(CMD_STOP, 8'h00);
   endtask

   task automatic test_command_set();
      write_half_period(8'd1);
      run_command(CMD_START, 8'h00);
      sda_one_pct = 0;
      run_command(CMD_WRITE, 8'h00);
      run_command(CMD_READ, 8'h00);
      sda_one_pct = 100;
      run_command(CMD_WRITE, 8'hFF);
      run_command(CMD_READ, 8'h00);
      sda_one_pct = 50;
      run_command(CMD_WRITE, 8'hA5);
      run_command(CMD_READ, 8'h00);
      run_command(CMD_ACK, 8'h00);
      run_command(CMD_NACK, 8'h00);
      run_command(CMD_START, 8'h00);
      run_command(CMD_STOP, 8'h00);
   endtask

   task automatic test_zero_period();
      write_half_period(8'd0);
      run_command(CMD_START, 8'h00);
      run_command(CMD_WRITE, 8'h3C);
      run_command(CMD_STOP, 8'h00);
   endtask

   task automatic test_ignored_requests();
      bus_tick(1'b1, REQ_UNUSED_LO, 8'hFF);
      bus_tick(1'b1, REQ_UNUSED_HI, 8'h00);
      bus_tick(1'b0, CMD_WRITE, 8'h81);
      noise_pct = 100;
      run_command(CMD_WRITE, 8'h5A);
      noise_pct = 0;
   endtask

   task automatic test_clock_stretching();
      scl_low_pct = 80;
      run_command(CMD_READ, 8'h00);
      run_command(CMD_WRITE, 8'hC3);
      run_command(CMD_STOP, 8'h00);
      scl_low_pct = 0;
   endtask

   task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                      input logic [7:0] period, input int unsigned n);
      int unsigned stop_at;
      write_half_period(period);
      idle_pct  = idle;
      stall_pct = stall;
      noise_pct = 20;
      stop_at   = ticks_sent + n;
      while (ticks_sent < stop_at) begin
         scl_low_pct = ($urandom_range(3) == 0) ? 40 : 3;
         sda_one_pct = ($urandom_range(4) == 0) ? 90 : 50;
         if ($urandom_range(99) < 85) begin
            run_command($urandom_range(5), $urandom);
         end else begin
            bus_tick($urandom_range(1), $urandom_range(7), $urandom);
         end
      end
      noise_pct = 0;
   endtask

   task automatic test_slow_bus();
      write_half_period(8'd255);
      idle_pct  = 7;
      stall_pct = 7;
      scl_low_pct = 5;
      run_command(CMD_STOP, 8'h00);
      scl_low_pct = 0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_period();
      test_command_set();
      test_zero_period();
      test_ignored_requests();
      test_clock_stretching();
      test_random_traffic(0, 0, 8'd1, 120);
      test_random_traffic(60, 0, 8'd0, 120);
      test_random_traffic(0, 60, 8'd2, 120);
      test_random_traffic(7, 7, 8'd1, 120);
      test_slow_bus();
      req_valid <= 1'b0;
      while (bus_levels_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
